FILE: hw/rtl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// Meter frame receiver package
// Shared types and frame constants for the meter frame receiver.
// ----------------------------------------------------------------------------
package fmr_pkg;

  // Result codes reported for each received byte.
  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_ACCEPT        = 3'd1,
    EV_ADDR_MISMATCH = 3'd2,
    EV_CHECKSUM_BAD  = 3'd3,
    EV_OVERLENGTH    = 3'd4
  } fmr_event_e;

  // Receiver mode: hunting for the start pair or inside a locked frame.
  typedef enum logic [1:0] {
    MODE_HUNT  = 2'b01,
    MODE_FRAME = 2'b10
  } fmr_mode_e;

  // Frame marker bytes.
  localparam logic [7:0] SYNC_START  = 8'h68;
  localparam logic [7:0] SYNC_SECOND = 8'h10;
  localparam logic [7:0] END_BYTE    = 8'h16;
  localparam logic [7:0] BCAST_BYTE  = 8'hAA;

  // Byte positions within a frame.
  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] HEADER_LEN     = 9'd13;
  localparam logic [CNT_W-1:0] POS_LOCKED     = 9'd2;
  localparam logic [CNT_W-1:0] POS_ADDR_FIRST = 9'd2;
  localparam logic [CNT_W-1:0] POS_ADDR_LAST  = 9'd8;
  localparam logic [CNT_W-1:0] POS_CTRL       = 9'd9;
  localparam logic [CNT_W-1:0] POS_LEN        = 9'd10;
  localparam logic [CNT_W-1:0] POS_IDENT_LO   = 9'd11;
  localparam logic [CNT_W-1:0] POS_IDENT_HI   = 9'd12;

  localparam int unsigned ADDR_W = 56;

  // One result transaction.
  typedef struct packed {
    fmr_event_e  event_res;
    logic [7:0]  control_code;
    logic [7:0]  data_length;
    logic [7:0]  ident_low;
    logic [7:0]  ident_high;
    logic        broadcast;
  } fmr_result_t;

  // Parser status seen by the top level.
  typedef struct packed {
    logic hunting;
    logic frame_end;
  } fmr_status_t;

endpackage

FILE: hw/rtl/meter_frame_receiver.sv
// ----------------------------------------------------------------------------
// Meter frame receiver
// Byte-serial receiver for meter request frames with address, length and
// checksum checks.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid_i/rx_ready_o/rx_byte_i) takes one received byte per
//   transaction. Every accepted byte yields exactly one result transaction on
//   the res channel; event_res_o is zero for bytes that do not end a frame.
//   cfg (cfg_valid_i/cfg_ready_o/meter_address_i), always ready, writes the
//   seven-byte meter address; user must write it only while idle, unchecked.
// Result timing and throughput:
//   A result is registered in the cycle after its byte is accepted, and one
//   byte per cycle is taken while rx_ready_o is high. The per-byte decision
//   is one compare/add stage between frame state and result register.
// Reset:
//   The receiver hunts for the start pair, the meter address is zero, and no
//   result is pending.
// Stalls:
//   While a result waits and res_ready_i is low, rx_ready_o drops; a new byte
//   is taken in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module meter_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [55:0] meter_address_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  control_code_o,
  output logic [7:0]  data_length_o,
  output logic [7:0]  ident_low_o,
  output logic [7:0]  ident_high_o,
  output logic        broadcast_o
);
  import fmr_pkg::*;

  fmr_result_t parse_result;
  fmr_result_t out_result;
  fmr_status_t parse_status;
  logic        rx_accept;

  assign cfg_ready_o = 1'b1;
  assign rx_accept   = rx_valid_i && rx_ready_o;

  // Frame state and per-byte decision.
  fmr_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .meter_address_i (meter_address_i),
    .rx_accept_i     (rx_accept),
    .rx_byte_i       (rx_byte_i),
    .result_o        (parse_result),
    .status_o        (parse_status)
  );

  // Result register.
  fmr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_valid_i),
    .in_ready_o  (rx_ready_o),
    .result_i    (parse_result),
    .out_valid_o (res_valid_o),
    .out_ready_i (res_ready_i),
    .result_o    (out_result)
  );

  assign event_res_o    = out_result.event_res;
  assign control_code_o = out_result.control_code;
  assign data_length_o  = out_result.data_length;
  assign ident_low_o    = out_result.ident_low;
  assign ident_high_o   = out_result.ident_high;
  assign broadcast_o    = out_result.broadcast;

  // Every accepted byte leaves a result pending in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_accept |=> res_valid_o)
    else $error("accepted byte produced no result");

  // A byte that ends or drops a frame returns the parser to hunting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_accept && parse_status.frame_end) |=> parse_status.hunting)
    else $error("parser did not return to hunting after frame end");

  // A frame cannot end while hunting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_status.hunting |-> !parse_status.frame_end)
    else $error("frame end reported while hunting");

  // A result without an event carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && event_res_o == EV_NONE) |->
      (control_code_o == 8'h00 && data_length_o == 8'h00 && ident_low_o == 8'h00
       && ident_high_o == 8'h00 && !broadcast_o))
    else $error("non-event result carries nonzero fields");

endmodule

FILE: hw/rtl/fmr_parser.sv
// ----------------------------------------------------------------------------
// Meter frame parser
// Holds the frame state and the meter address register, and works out the
// result for one received byte combinationally.
// ----------------------------------------------------------------------------
module fmr_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [fmr_pkg::ADDR_W-1:0]   meter_address_i,
  input  logic                         rx_accept_i,
  input  logic [7:0]                   rx_byte_i,
  output fmr_pkg::fmr_result_t         result_o,
  output fmr_pkg::fmr_status_t         status_o
);
  import fmr_pkg::*;

  logic [ADDR_W-1:0] meter_address_q;
  fmr_mode_e         mode_q, mode_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        prev_q, prev_d;
  logic [7:0]        sum_q, sum_d;
  logic              id_match_q, id_match_d;
  logic              bcast_q, bcast_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic [15:0]       ident_q, ident_d;

  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  addr_off;
  logic [2:0]        addr_sel;
  logic              addr_window;
  logic [7:0]        want;
  fmr_event_e        ev;

  // Address byte selection for positions two through eight.
  assign cnt_inc     = cnt_q + 9'd1;
  assign addr_off    = cnt_q - POS_ADDR_FIRST;
  assign addr_sel    = addr_off[2:0];
  assign addr_window = (cnt_q >= POS_ADDR_FIRST) && (cnt_q <= POS_ADDR_LAST);

  always_comb begin
    case (addr_sel)
      3'd0:    want = meter_address_q[7:0];
      3'd1:    want = meter_address_q[15:8];
      3'd2:    want = meter_address_q[23:16];
      3'd3:    want = meter_address_q[31:24];
      3'd4:    want = meter_address_q[39:32];
      3'd5:    want = meter_address_q[47:40];
      3'd6:    want = meter_address_q[55:48];
      default: want = 8'h00;
    endcase
  end

  // Next state and result for the current byte.
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    sum_d      = sum_q;
    id_match_d = id_match_q;
    bcast_d    = bcast_q;
    len_d      = len_q;
    ctrl_d     = ctrl_q;
    ident_d    = ident_q;
    total      = HEADER_LEN;
    ev         = EV_NONE;

    case (mode_q)
      MODE_HUNT: begin
        if (cnt_q == '0) begin
          prev_d = rx_byte_i;
          cnt_d  = 9'd1;
        end else if (prev_q == SYNC_START && rx_byte_i == SYNC_SECOND) begin
          mode_d     = MODE_FRAME;
          cnt_d      = POS_LOCKED;
          sum_d      = SYNC_START;
          prev_d     = SYNC_SECOND;
          id_match_d = 1'b1;
          bcast_d    = 1'b1;
          len_d      = 8'h00;
          ctrl_d     = 8'h00;
          ident_d    = 16'h0000;
        end else if (rx_byte_i == SYNC_START) begin
          prev_d = SYNC_START;
          cnt_d  = 9'd1;
        end else begin
          cnt_d = '0;
        end
      end

      MODE_FRAME: begin
        // Capture header fields by position.
        if (addr_window) begin
          if (rx_byte_i != want) id_match_d = 1'b0;
          if (rx_byte_i != BCAST_BYTE) bcast_d = 1'b0;
        end else begin
          case (cnt_q)
            POS_CTRL:     ctrl_d        = rx_byte_i;
            POS_LEN:      len_d         = rx_byte_i;
            POS_IDENT_LO: ident_d[7:0]  = rx_byte_i;
            POS_IDENT_HI: ident_d[15:8] = rx_byte_i;
            default:      ;
          endcase
        end

        cnt_d = cnt_inc;
        total = HEADER_LEN + {1'b0, len_d};

        // End of frame, overlength drop, or keep summing.
        if (cnt_inc >= HEADER_LEN && cnt_inc == total && rx_byte_i == END_BYTE) begin
          if (id_match_d || bcast_d) begin
            ev = (prev_q == sum_q) ? EV_ACCEPT : EV_CHECKSUM_BAD;
          end else begin
            ev = EV_ADDR_MISMATCH;
          end
          mode_d = MODE_HUNT;
          cnt_d  = '0;
        end else if (cnt_inc >= HEADER_LEN && cnt_inc > total) begin
          ev     = EV_OVERLENGTH;
          mode_d = MODE_HUNT;
          cnt_d  = '0;
        end else begin
          sum_d  = sum_q + prev_q;
          prev_d = rx_byte_i;
        end
      end

      default: begin
        mode_d = MODE_HUNT;
        cnt_d  = '0;
      end
    endcase
  end

  // Result fields are zero when no frame ends on this byte.
  always_comb begin
    result_o.event_res = ev;
    if (ev == EV_NONE) begin
      result_o.control_code = 8'h00;
      result_o.data_length  = 8'h00;
      result_o.ident_low    = 8'h00;
      result_o.ident_high   = 8'h00;
      result_o.broadcast    = 1'b0;
    end else begin
      result_o.control_code = ctrl_d;
      result_o.data_length  = len_d;
      result_o.ident_low    = ident_d[7:0];
      result_o.ident_high   = ident_d[15:8];
      result_o.broadcast    = bcast_d;
    end
  end

  assign status_o.hunting   = (mode_q == MODE_HUNT);
  assign status_o.frame_end = (ev != EV_NONE);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_address_q <= '0;
    end else if (cfg_valid_i) begin
      meter_address_q <= meter_address_i;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HUNT;
      cnt_q      <= '0;
      prev_q     <= 8'h00;
      sum_q      <= 8'h00;
      id_match_q <= 1'b1;
      bcast_q    <= 1'b1;
      len_q      <= 8'h00;
      ctrl_q     <= 8'h00;
      ident_q    <= 16'h0000;
    end else if (rx_accept_i) begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      prev_q     <= prev_d;
      sum_q      <= sum_d;
      id_match_q <= id_match_d;
      bcast_q    <= bcast_d;
      len_q      <= len_d;
      ctrl_q     <= ctrl_d;
      ident_q    <= ident_d;
    end
  end

endmodule

FILE: hw/rtl/fmr_out_stage.sv
// ----------------------------------------------------------------------------
// Meter frame result register
// Output register with valid/ready that takes a new result in the same cycle
// the held one is taken.
// ----------------------------------------------------------------------------
module fmr_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fmr_pkg::fmr_result_t  result_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output fmr_pkg::fmr_result_t  result_o
);
  import fmr_pkg::*;

  logic        valid_q;
  fmr_result_t data_q;

  // Space is free when empty or when the held transaction leaves now.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= result_i;
    end
  end

endmodule
